@@ sv/fpdgl_pkg.sv @@
`default_nettype none

package fpdgl_pkg;

    localparam int unsigned BinWidth  = 32;
    localparam int unsigned NumDigits = 10;
    localparam int unsigned BcdWidth  = 4 * NumDigits;
    localparam int unsigned DdStages  = 4;
    localparam int unsigned DdBits    = BinWidth / DdStages;

    localparam logic [3:0] CODE_POINT = 4'd10;
    localparam logic [3:0] CODE_MINUS = 4'd11;
    localparam logic [3:0] MAX_FRAC   = 4'd9;
    localparam logic [7:0] WIDTH_RST  = 8'd16;

    typedef enum logic [3:0] {
        PH_MINUS = 4'b0001,
        PH_FRAC  = 4'b0010,
        PH_POINT = 4'b0100,
        PH_INT   = 4'b1000
    } phase_t;

    // Shift-and-add-3 working pair: packed BCD digits and the binary bits still to shift in.
    typedef struct packed {
        logic [BcdWidth-1:0] bcd;
        logic [BinWidth-1:0] bin;
    } dd_t;

    typedef struct packed {
        logic        neg;
        logic [3:0]  dec;
        logic [15:0] x0;
        logic [15:0] xd;
        logic [15:0] y;
        dd_t         dd;
    } stage_t;

    typedef struct packed {
        logic                neg;
        logic [3:0]          dec;
        logic [15:0]         x0;
        logic [15:0]         xs;
        logic [15:0]         y;
        logic [BcdWidth-1:0] bcd;
        logic [3:0]          int_left;
    } fin_t;

    // One slice of the conversion: DdBits shift-and-add-3 steps.
    function automatic dd_t dabble_slice(dd_t d);
        dd_t r;
        r = d;
        for (int s = 0; s < DdBits; s++) begin
            for (int n = 0; n < NumDigits; n++) begin
                if (r.bcd[4*n +: 4] >= 4'd5) begin
                    r.bcd[4*n +: 4] = r.bcd[4*n +: 4] + 4'd3;
                end
            end
            r = r << 1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/fixed_point_decimal_glyph_layout.sv @@
`default_nettype none

// Channel  | Direction | Contents
// s_axis   | in        | tdata: pos_x, pos_y, value, frac_digits
// m_axis   | out       | tdata: glyph_code, glyph_x, glyph_y; tlast on the final glyph
// cfg      | in        | glyph_width, written at any edge with cfg_wr_en high
//
// A number goes through an entry stage, four binary-to-BCD stages of eight bits each and a
// layout stage, each registered, before its first glyph reaches the output serializer.
// The output serializer then gives one glyph a cycle while m_tready is high: a number has 1
// to 12 glyphs, and that serializer sets the sustained rate.
// Reset is synchronous and active low; it empties the pipeline and sets glyph_width to 16.
// A stalled output holds its glyph, and the stages behind it fill up before s_tready drops.
module fixed_point_decimal_glyph_layout (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] pos_x, [31:16] pos_y, [63:32] value, [67:64] frac_digits, [71:68] zero
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] glyph_code, [19:4] glyph_x, [35:20] glyph_y, [39:36] zero
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    import fpdgl_pkg::*;

    localparam int unsigned NumSt = DdStages + 1;

    logic [7:0] glyph_width_reg;

    stage_t st_reg  [NumSt];
    stage_t st_next [NumSt];
    logic [NumSt-1:0] vld_reg, vld_next;
    logic [NumSt:0]   rdy;

    fin_t fin_reg, fin_next;
    logic fin_valid_reg, fin_valid_next;
    logic fin_ready;

    logic                ser_valid_reg, ser_valid_next;
    phase_t              phase_reg, phase_next;
    logic [BcdWidth-1:0] digits_reg, digits_next;
    logic [3:0]          frac_left_reg, frac_left_next;
    logic [3:0]          int_left_reg, int_left_next;
    logic [15:0]         x_reg, x_next;
    logic [15:0]         xd_reg, xd_next;
    logic [15:0]         y_reg, y_next;

    logic        out_fire, last_glyph, ser_load;
    logic [3:0]  code;
    logic [15:0] w16;

    logic        in_neg;
    logic [31:0] in_value, in_mag;
    logic [3:0]  in_frac, in_dec;

    logic [3:0]  nd, digits, span;
    logic [15:0] prod;

    assign w16 = {8'd0, glyph_width_reg};

    // Entry stage inputs.
    always_comb begin
        in_value = s_tdata[63:32];
        in_frac  = s_tdata[67:64];
        in_neg   = in_value[31];
        in_mag   = in_neg ? (~in_value + 32'd1) : in_value;
        in_dec   = (in_frac > MAX_FRAC) ? MAX_FRAC : in_frac;
    end

    // Stage contents and the ready chain from the serializer back to the input.
    always_comb begin
        st_next[0].neg    = in_neg;
        st_next[0].dec    = in_dec;
        st_next[0].x0     = s_tdata[15:0];
        st_next[0].xd     = s_tdata[15:0] + (in_neg ? w16 : 16'd0);
        st_next[0].y      = s_tdata[31:16];
        st_next[0].dd.bcd = '0;
        st_next[0].dd.bin = in_mag;
        for (int k = 1; k < NumSt; k++) begin
            st_next[k]    = st_reg[k-1];
            st_next[k].dd = dabble_slice(st_reg[k-1].dd);
        end

        rdy[NumSt] = fin_ready;
        for (int k = NumSt - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NumSt; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_tready = rdy[0];

    // Layout stage: number of digits shown and the x of the rightmost digit.
    always_comb begin
        nd = 4'd0;
        for (int n = 0; n < NumDigits; n++) begin
            if (st_reg[NumSt-1].dd.bcd[4*n +: 4] != 4'd0) begin
                nd = 4'(n + 1);
            end
        end
        digits = (nd > st_reg[NumSt-1].dec + 4'd1) ? nd : st_reg[NumSt-1].dec + 4'd1;
        span   = digits - 4'd1 + ((st_reg[NumSt-1].dec != 4'd0) ? 4'd1 : 4'd0);
        prod   = w16 * {12'd0, span};

        fin_next.neg      = st_reg[NumSt-1].neg;
        fin_next.dec      = st_reg[NumSt-1].dec;
        fin_next.x0       = st_reg[NumSt-1].x0;
        fin_next.xs       = st_reg[NumSt-1].xd + prod;
        fin_next.y        = st_reg[NumSt-1].y;
        fin_next.bcd      = st_reg[NumSt-1].dd.bcd;
        fin_next.int_left = digits - st_reg[NumSt-1].dec;
        fin_valid_next    = fin_ready ? vld_reg[NumSt-1] : fin_valid_reg;
    end

    // Output serializer: minus, fractional digits, point, integer digits.
    always_comb begin
        out_fire   = ser_valid_reg && m_tready;
        last_glyph = (phase_reg == PH_INT) && (int_left_reg == 4'd1);
        ser_load   = !ser_valid_reg || (out_fire && last_glyph);
        fin_ready  = !fin_valid_reg || ser_load;

        ser_valid_next = ser_valid_reg;
        phase_next     = phase_reg;
        digits_next    = digits_reg;
        frac_left_next = frac_left_reg;
        int_left_next  = int_left_reg;
        x_next         = x_reg;
        xd_next        = xd_reg;
        y_next         = y_reg;

        if (ser_load) begin
            ser_valid_next = fin_valid_reg;
            if (fin_reg.neg) begin
                phase_next = PH_MINUS;
            end else if (fin_reg.dec != 4'd0) begin
                phase_next = PH_FRAC;
            end else begin
                phase_next = PH_INT;
            end
            digits_next    = fin_reg.bcd;
            frac_left_next = fin_reg.dec;
            int_left_next  = fin_reg.int_left;
            x_next         = fin_reg.neg ? fin_reg.x0 : fin_reg.xs;
            xd_next        = fin_reg.xs;
            y_next         = fin_reg.y;
        end else if (out_fire) begin
            case (phase_reg)
                PH_MINUS: begin
                    x_next     = xd_reg;
                    phase_next = (frac_left_reg != 4'd0) ? PH_FRAC : PH_INT;
                end
                PH_FRAC: begin
                    digits_next    = digits_reg >> 4;
                    x_next         = x_reg - w16;
                    frac_left_next = frac_left_reg - 4'd1;
                    if (frac_left_reg == 4'd1) begin
                        phase_next = PH_POINT;
                    end
                end
                PH_POINT: begin
                    x_next     = x_reg - w16;
                    phase_next = PH_INT;
                end
                PH_INT: begin
                    digits_next   = digits_reg >> 4;
                    x_next        = x_reg - w16;
                    int_left_next = int_left_reg - 4'd1;
                end
                default: begin
                    phase_next = PH_INT;
                end
            endcase
        end
    end

    always_comb begin
        case (phase_reg)
            PH_MINUS: code = CODE_MINUS;
            PH_POINT: code = CODE_POINT;
            PH_FRAC:  code = digits_reg[3:0];
            PH_INT:   code = digits_reg[3:0];
            default:  code = digits_reg[3:0];
        endcase
    end

    assign m_tvalid = ser_valid_reg;
    assign m_tdata  = {4'd0, y_reg, x_reg, code};
    assign m_tlast  = last_glyph;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_width_reg <= WIDTH_RST;
            vld_reg         <= '0;
            fin_valid_reg   <= 1'b0;
            ser_valid_reg   <= 1'b0;
            phase_reg       <= PH_INT;
            frac_left_reg   <= 4'd0;
            int_left_reg    <= 4'd1;
        end else begin
            if (cfg_wr_en) begin
                glyph_width_reg <= cfg_wr_data;
            end
            vld_reg       <= vld_next;
            fin_valid_reg <= fin_valid_next;
            ser_valid_reg <= ser_valid_next;
            phase_reg     <= phase_next;
            frac_left_reg <= frac_left_next;
            int_left_reg  <= int_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NumSt; k++) begin
            if (rdy[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
        if (fin_ready) begin
            fin_reg <= fin_next;
        end
        digits_reg <= digits_next;
        x_reg      <= x_next;
        xd_reg     <= xd_next;
        y_reg      <= y_next;
    end

    // A fractional glyph always has at least itself left to give.
    a_frac_left: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg && (phase_reg == PH_FRAC) |-> frac_left_reg != 4'd0)
        else $error("fractional phase with no digits left");

    // Every number ends on an integer digit, so the count never runs out early.
    a_int_left: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> int_left_reg != 4'd0)
        else $error("integer digit count reached zero");

    // Digit glyphs carry decimal digits only.
    a_bcd_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg && (phase_reg == PH_FRAC || phase_reg == PH_INT)
            |-> digits_reg[3:0] <= 4'd9)
        else $error("digit glyph holds a non-decimal code");

    // A finished layout that the serializer cannot take stays in place.
    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid_reg && !ser_load |=> fin_valid_reg)
        else $error("layout stage dropped a number");

endmodule

`default_nettype wire
